### hdl/lirr_pkg.sv
// Shared constants, widths and types for the linear interpolating resampler.
// Used by lirr_divider and linear_interp_rational_resampler; no dependencies.
package lirr_pkg;

   // Sample layout
   localparam int NUM_CHANNELS = 6;
   localparam int SAMPLE_BITS  = 16;
   localparam int CH_IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Register and field widths
   localparam int UP_BITS    = 6;
   localparam int DOWN_BITS  = 7;
   localparam int STEP_BITS  = 16;
   localparam int PHASE_BITS = 6;
   localparam int TIME_BITS  = 40;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // Register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UP_FACTOR   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DOWN_FACTOR = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_INPUT_STEP  = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UP_STEP     = 2'd3;

   // Register reset values
   localparam logic [UP_BITS-1:0]   UP_FACTOR_RST   = 6'd4;
   localparam logic [DOWN_BITS-1:0] DOWN_FACTOR_RST = 7'd5;
   localparam logic [STEP_BITS-1:0] INPUT_STEP_RST  = 16'd1707;
   localparam logic [STEP_BITS-1:0] UP_STEP_RST     = 16'd427;

   // Datapath widths
   localparam int SPAN_BITS  = PHASE_BITS + STEP_BITS;          // k * up_step
   localparam int DIFF_BITS  = SAMPLE_BITS + 1;                 // r1 - r0
   localparam int PROD_BITS  = DIFF_BITS + SPAN_BITS + 1;       // signed product
   localparam int RADIX_BITS = 4;                               // quotient bits per cycle
   localparam int DIV_BITS   = ((PROD_BITS - 1 + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
   localparam int DIV_STEPS  = DIV_BITS / RADIX_BITS;
   localparam int DIV_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);
   localparam int ACC_BITS   = DIV_BITS + 2;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_BITS = ((NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((TIME_BITS + NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Divider command and status
   typedef struct packed {
      logic                 start;
      logic [DIV_BITS-1:0]  num;
      logic [STEP_BITS-1:0] den;
   } lirr_div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [DIV_BITS-1:0] quot;
   } lirr_div_rsp_type;

endpackage

### hdl/linear_interp_rational_resampler.sv
// Top level of the L/M linear interpolating resampler for six-channel eye samples.
// Depends on lirr_pkg and lirr_divider (shared iterative divider).
//
// Usage:
//  - req_* stream carries one eye sample per request: tdata holds the six
//    Q12.4 channels, tuser the first-of-set flag.
//  - rsp_* stream returns at most one interpolated point per request:
//    timestamp (ms, 8 fraction bits) plus the six interpolated channels.
//  - csr_* is a write-only register port (up/down factors, input and
//    upsampled periods); write it only while no request is in flight.
// Request handling:
//  - A request that starts a set, or whose pair holds no kept point, is
//    absorbed in its accept cycle; the next request may follow at once.
//  - A request that yields a point runs the sequencer: a span state for
//    k*up_step, then per channel a multiply, a divider load, the divider run
//    and an accumulate/saturate state, then an output load. The single
//    shared divider sets the pace. req_tready is low while the sequencer runs.
// Reset: synchronous, active high; registers return to their defaults, the
//  previous-sample store, phase and time base clear, no response is pending.
// Backpressure: the result sits in an output register until rsp_tready; a new
//  request is taken meanwhile. If that request yields a point, the sequencer
//  holds it in the output-load state, with req_tready low, until the register
//  frees up.
module linear_interp_rational_resampler (
   input  logic clock,
   input  logic reset,

   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] x_right, [31:16] y_right, [47:32] x_left, [63:48] y_left,
   // [79:64] pupil_left, [95:80] pupil_right
   input  logic [lirr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [0] first_of_set
   input  logic                               req_tuser,

   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [39:0] time_ms, [55:40] out_x_right, [71:56] out_y_right,
   // [87:72] out_x_left, [103:88] out_y_left, [119:104] out_pupil_left,
   // [135:120] out_pupil_right
   output logic [lirr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,

   // register write port
   input  logic                               csr_wr_en,
   input  logic [lirr_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [lirr_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SPAN  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_DIVGO = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   localparam logic [lirr_pkg::CH_IDX_BITS-1:0] CH_LAST =
      lirr_pkg::CH_IDX_BITS'(lirr_pkg::NUM_CHANNELS - 1);

   localparam logic signed [lirr_pkg::ACC_BITS-1:0] SAT_HI =
      {{(lirr_pkg::ACC_BITS - lirr_pkg::SAMPLE_BITS + 1){1'b0}},
       {(lirr_pkg::SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [lirr_pkg::ACC_BITS-1:0] SAT_LO = ~SAT_HI;

   // configuration registers
   logic [lirr_pkg::UP_BITS-1:0]   up_factor_ff;
   logic [lirr_pkg::DOWN_BITS-1:0] down_factor_ff;
   logic [lirr_pkg::STEP_BITS-1:0] input_step_ff;
   logic [lirr_pkg::STEP_BITS-1:0] up_step_ff;

   // resampler state
   lirr_pkg::sample_type           prev_ff [lirr_pkg::NUM_CHANNELS];
   lirr_pkg::sample_type           cur_ff  [lirr_pkg::NUM_CHANNELS];
   lirr_pkg::sample_type           res_ff  [lirr_pkg::NUM_CHANNELS];
   lirr_pkg::sample_type           req_ch  [lirr_pkg::NUM_CHANNELS];
   logic                           have_prev_ff;
   logic [lirr_pkg::PHASE_BITS-1:0] phase_ff;
   logic [lirr_pkg::TIME_BITS-1:0]  time_base_ff;

   // sequencer and datapath registers
   logic [2:0]                       state_ff, state_in;
   logic [lirr_pkg::CH_IDX_BITS-1:0] ch_ff;
   logic [lirr_pkg::SPAN_BITS-1:0]   span_ff;
   logic signed [lirr_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [lirr_pkg::ACC_BITS-1:0]  qs_ff;

   // response register
   logic                               rsp_valid_ff;
   logic [lirr_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;

   // combinational helpers
   logic                                  req_fire;
   logic                                  out_load;
   logic signed [lirr_pkg::DIFF_BITS-1:0] diff_s;
   logic [lirr_pkg::PROD_BITS-1:0]        prod_mag;
   logic signed [lirr_pkg::ACC_BITS-1:0]  acc_v;
   lirr_pkg::sample_type                  sat_v;
   logic [lirr_pkg::PHASE_BITS+1:0]       phase_sum;
   logic [lirr_pkg::PHASE_BITS-1:0]       phase_nxt;
   logic [lirr_pkg::TIME_BITS-1:0]        time_out;
   logic [lirr_pkg::RSP_DATA_BITS-1:0]    rsp_data_in;

   lirr_pkg::lirr_div_req_type div_req;
   lirr_pkg::lirr_div_rsp_type div_rsp;

   for (genvar g = 0; g < lirr_pkg::NUM_CHANNELS; g++) begin : g_unpack
      assign req_ch[g] = req_tdata[g*lirr_pkg::SAMPLE_BITS +: lirr_pkg::SAMPLE_BITS];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // channel difference and product magnitude for the divider
   assign diff_s   = lirr_pkg::DIFF_BITS'(cur_ff[ch_ff]) - lirr_pkg::DIFF_BITS'(prev_ff[ch_ff]);
   assign prod_mag = prod_ff[lirr_pkg::PROD_BITS-1] ? lirr_pkg::PROD_BITS'(-prod_ff)
                                                    : lirr_pkg::PROD_BITS'(prod_ff);

   assign div_req.start = (state_ff == S_DIVGO);
   assign div_req.num   = lirr_pkg::DIV_BITS'(prod_mag);
   assign div_req.den   = input_step_ff;

   lirr_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // r0 + quotient, clamped to the sample range
   always_comb begin
      acc_v = lirr_pkg::ACC_BITS'(prev_ff[ch_ff]) + qs_ff;
      if (acc_v > SAT_HI) begin
         sat_v = lirr_pkg::SAMPLE_BITS'(SAT_HI);
      end else if (acc_v < SAT_LO) begin
         sat_v = lirr_pkg::SAMPLE_BITS'(SAT_LO);
      end else begin
         sat_v = lirr_pkg::SAMPLE_BITS'(acc_v);
      end
   end

   // next kept-point index: r + M - L, floored at zero, 6-bit wrap
   always_comb begin
      phase_sum = {2'b00, phase_ff} + {1'b0, down_factor_ff};
      if (phase_sum >= {2'b00, up_factor_ff}) begin
         phase_nxt = lirr_pkg::PHASE_BITS'(phase_sum - {2'b00, up_factor_ff});
      end else begin
         phase_nxt = '0;
      end
   end

   assign time_out = time_base_ff + lirr_pkg::TIME_BITS'(span_ff);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[lirr_pkg::TIME_BITS-1:0] = time_out;
      for (int c = 0; c < lirr_pkg::NUM_CHANNELS; c++) begin
         rsp_data_in[lirr_pkg::TIME_BITS + c*lirr_pkg::SAMPLE_BITS +: lirr_pkg::SAMPLE_BITS] =
            res_ff[c];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && !req_tuser && have_prev_ff && (phase_ff < up_factor_ff)) begin
               state_in = S_SPAN;
            end
         end
         S_SPAN:  state_in = S_MUL;
         S_MUL:   state_in = S_DIVGO;
         S_DIVGO: state_in = S_DIV;
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = (ch_ff == CH_LAST) ? S_OUT : S_MUL;
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         up_factor_ff   <= lirr_pkg::UP_FACTOR_RST;
         down_factor_ff <= lirr_pkg::DOWN_FACTOR_RST;
         input_step_ff  <= lirr_pkg::INPUT_STEP_RST;
         up_step_ff     <= lirr_pkg::UP_STEP_RST;
         have_prev_ff   <= 1'b0;
         phase_ff       <= '0;
         time_base_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int c = 0; c < lirr_pkg::NUM_CHANNELS; c++) begin
            prev_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_addr)
               lirr_pkg::CSR_UP_FACTOR:   up_factor_ff   <= csr_wdata[lirr_pkg::UP_BITS-1:0];
               lirr_pkg::CSR_DOWN_FACTOR: down_factor_ff <= csr_wdata[lirr_pkg::DOWN_BITS-1:0];
               lirr_pkg::CSR_INPUT_STEP:  input_step_ff  <= csr_wdata[lirr_pkg::STEP_BITS-1:0];
               lirr_pkg::CSR_UP_STEP:     up_step_ff     <= csr_wdata[lirr_pkg::STEP_BITS-1:0];
               default: ;
            endcase
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (req_fire) begin
            if (req_tuser || !have_prev_ff) begin
               // set start: store only
               have_prev_ff <= 1'b1;
               phase_ff     <= '0;
               for (int c = 0; c < lirr_pkg::NUM_CHANNELS; c++) begin
                  prev_ff[c] <= req_ch[c];
               end
            end else if (phase_ff >= up_factor_ff) begin
               // no kept point in this pair
               phase_ff     <= phase_ff - up_factor_ff;
               time_base_ff <= time_base_ff + lirr_pkg::TIME_BITS'(input_step_ff);
               for (int c = 0; c < lirr_pkg::NUM_CHANNELS; c++) begin
                  prev_ff[c] <= req_ch[c];
               end
            end
         end

         if (out_load) begin
            phase_ff     <= phase_nxt;
            time_base_ff <= time_base_ff + lirr_pkg::TIME_BITS'(input_step_ff);
            for (int c = 0; c < lirr_pkg::NUM_CHANNELS; c++) begin
               prev_ff[c] <= cur_ff[c];
            end
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int c = 0; c < lirr_pkg::NUM_CHANNELS; c++) begin
            cur_ff[c] <= req_ch[c];
         end
      end
      if (state_ff == S_SPAN) begin
         span_ff <= {{lirr_pkg::STEP_BITS{1'b0}}, phase_ff} *
                    {{lirr_pkg::PHASE_BITS{1'b0}}, up_step_ff};
         ch_ff   <= '0;
      end
      if (state_ff == S_MUL) begin
         prod_ff <= lirr_pkg::PROD_BITS'(diff_s) *
                    lirr_pkg::PROD_BITS'($signed({1'b0, span_ff}));
      end
      if ((state_ff == S_DIV) && div_rsp.done) begin
         // zero input period: no interpolation, keep r0
         if (input_step_ff == '0) begin
            qs_ff <= '0;
         end else if (prod_ff[lirr_pkg::PROD_BITS-1]) begin
            qs_ff <= -$signed({2'b00, div_rsp.quot});
         end else begin
            qs_ff <= $signed({2'b00, div_rsp.quot});
         end
      end
      if (state_ff == S_ACC) begin
         res_ff[ch_ff] <= sat_v;
         ch_ff         <= ch_ff + 1'b1;
      end
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the divider runs only while the sequencer waits on it
   a_div_busy_in_div : assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> (state_ff == S_DIV))
      else $error("divider busy outside S_DIV");

   // a computed pair always starts from an accepted request
   a_span_from_accept : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPAN) |-> $past(req_fire))
      else $error("sequencer started without a request");

   // channel index stays in range while the datapath uses it
   a_ch_range : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL) || (state_ff == S_ACC)) |-> (ch_ff <= CH_LAST))
      else $error("channel index out of range");

   // a new response appears only from the output-load state
   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside S_OUT");

endmodule

### hdl/lirr_divider.sv
// Iterative unsigned restoring divider, RADIX_BITS quotient bits per cycle.
// Depends on lirr_pkg for widths and the command/status structs.
module lirr_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  lirr_pkg::lirr_div_req_type div_req,
   output lirr_pkg::lirr_div_rsp_type div_rsp
);

   logic [lirr_pkg::DIV_BITS-1:0]     num_ff, num_in, num_v;
   logic [lirr_pkg::STEP_BITS:0]      rem_ff, rem_in, rem_v;
   logic [lirr_pkg::STEP_BITS-1:0]    den_ff, den_in;
   logic [lirr_pkg::DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;

   // one radix step: RADIX_BITS shift/compare/subtract rounds
   always_comb begin
      rem_v = rem_ff;
      num_v = num_ff;
      for (int i = 0; i < lirr_pkg::RADIX_BITS; i++) begin
         rem_v = {rem_v[lirr_pkg::STEP_BITS-1:0], num_v[lirr_pkg::DIV_BITS-1]};
         num_v = {num_v[lirr_pkg::DIV_BITS-2:0], 1'b0};
         if (rem_v >= {1'b0, den_ff}) begin
            rem_v    = rem_v - {1'b0, den_ff};
            num_v[0] = 1'b1;
         end
      end
   end

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lirr_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = num_ff;

endmodule
